/* src/lodsel_pkg.sv */
// lodsel_pkg: types, register codes and saturating helpers shared by the
// texture LOD request select block. No dependencies.
package lodsel_pkg;

   localparam int unsigned LOD_W     = 5;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned BOUND_W   = 48;
   localparam int unsigned DENS_W    = 64;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;
   localparam int unsigned MAX_LANES = 4;

   localparam logic [BOUND_W-1:0] MAX48   = '1;
   localparam logic [DENS_W-1:0]  ONE_Q16 = 64'h0000_0000_0001_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXTURE_PRESENT = 3'd0,
      CSR_LOD_ENABLE      = 3'd1,
      CSR_ORIG_RES        = 3'd2,
      CSR_RADIUS_SCALE    = 3'd3,
      CSR_UV_SCALE_A      = 3'd4,
      CSR_UV_SCALE_B      = 3'd5,
      CSR_UV_SCALE_C      = 3'd6
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE       = 2'd0,
      KIND_FREE       = 2'd1,
      KIND_INVALIDATE = 2'd2,
      KIND_INTERVAL   = 2'd3
   } bound_kind_type;

   typedef struct packed {
      logic [31:0] screen_size;
      logic [31:0] world_radius;
      logic [31:0] uv_density_a;
      logic [31:0] uv_density_b;
      logic [31:0] uv_density_c;
      logic [1:0]  uv_count;
      logic        want_bounds;
   } lodsel_req_type;

   typedef struct packed {
      logic [LOD_W-1:0]   lod_level;
      logic [KIND_W-1:0]  bound_kind;
      logic [BOUND_W-1:0] bound_low;
      logic [BOUND_W-1:0] bound_high;
   } lodsel_rsp_type;

   // sideband that rides along the divider pipeline
   typedef struct packed {
      logic              active;
      logic              want;
      logic              any;
      logic [31:0]       screen;
      logic [DENS_W-1:0] mind;
   } lodsel_side_type;

   function automatic logic [BOUND_W-1:0] plus_eps(input logic [BOUND_W-1:0] x);
      logic [BOUND_W:0] s;
      s = {1'b0, x} + {14'b0, x[BOUND_W-1:13]};
      return s[BOUND_W] ? MAX48 : s[BOUND_W-1:0];
   endfunction

   function automatic logic [BOUND_W-1:0] minus_eps(input logic [BOUND_W-1:0] x);
      return x - {13'b0, x[BOUND_W-1:13]};
   endfunction

endpackage

/* src/lodsel_lane.sv */
// lodsel_lane: one density lane, registered 32x32 density product.
// Depends on lodsel_pkg.
module lodsel_lane
   import lodsel_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic              enable,
   input  logic [31:0]       density,
   input  logic [31:0]       scale,
   output logic [DENS_W-1:0] dens_ff,
   output logic              use_ff
);

   logic [DENS_W-1:0] dens_in;

   assign dens_in = {32'b0, density} * {32'b0, scale};

   always_ff @(posedge clock) begin
      if (load) begin
         dens_ff <= dens_in;
         use_ff  <= enable;
      end
   end

endmodule

/* src/lodsel_merge.sv */
// lodsel_merge: combines the lanes, finds the smallest positive density.
// Depends on lodsel_pkg.
module lodsel_merge
   import lodsel_pkg::*;
#(
   parameter int NLANES = 4
) (
   input  logic              clock,
   input  logic [DENS_W-1:0] dens [NLANES],
   input  logic              lane_use [NLANES],
   output logic              any_ff,
   output logic [DENS_W-1:0] mind_ff
);

   logic              any_in;
   logic [DENS_W-1:0] mind_in;

   always_comb begin
      any_in  = 1'b0;
      mind_in = '1;
      for (int j = 0; j < NLANES; j++) begin
         if (lane_use[j] && (dens[j] != '0)) begin
            any_in = 1'b1;
            if (dens[j] < mind_in) begin
               mind_in = dens[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      any_ff  <= any_in;
      mind_ff <= mind_in;
   end

endmodule

/* src/lodsel_div.sv */
// lodsel_div: fully pipelined radix-2 divider, (screen << 32) / mind,
// one quotient bit per stage. Depends on lodsel_pkg.
module lodsel_div
   import lodsel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  lodsel_side_type   side_in,
   output logic              valid_out,
   output lodsel_side_type   side_out,
   output logic [DENS_W-1:0] quot_out
);

   localparam int STAGES = DENS_W;

   logic [STAGES-1:0] valid_ff;
   logic [DENS_W-1:0] rem_ff  [STAGES];
   logic [DENS_W-1:0] quo_ff  [STAGES];
   lodsel_side_type   side_ff [STAGES];
   logic [DENS_W-1:0] rem_in  [STAGES];
   logic [DENS_W-1:0] quo_in  [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], valid_in};
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DENS_W-1:0] prev_rem;
      logic [DENS_W-1:0] prev_quo;
      lodsel_side_type   prev_side;
      logic              dbit;
      logic [DENS_W:0]   trial;
      logic [DENS_W:0]   diff;
      logic              ge;

      if (s == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_quo  = '0;
         assign prev_side = side_in;
      end else begin : g_next
         assign prev_rem  = rem_ff[s-1];
         assign prev_quo  = quo_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      if (s < 32) begin : g_sbit
         assign dbit = prev_side.screen[31-s];
      end else begin : g_zbit
         assign dbit = 1'b0;
      end

      assign trial     = {prev_rem, dbit};
      assign diff      = trial - {1'b0, prev_side.mind};
      assign ge        = (trial >= {1'b0, prev_side.mind});
      assign rem_in[s] = ge ? diff[DENS_W-1:0] : trial[DENS_W-1:0];
      assign quo_in[s] = {prev_quo[DENS_W-2:0], ge};

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
         side_ff[s] <= prev_side;
      end
   end

   assign valid_out = valid_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];
   assign quot_out  = quo_ff[STAGES-1];

endmodule

/* src/texture_lod_request_select.sv */
// texture_lod_request_select: texture mip LOD selection per draw request.
// Depends on lodsel_pkg, lodsel_lane, lodsel_merge, lodsel_div.
// Pipeline: the lane multiply registers load at the accepting edge, followed by the
// merge, divider, LOD, bound multiply and finish registers; finish drives the strobe.
// Throughput: one request per cycle; busy stays low, every stage is a pipe.
// Reset (synchronous, active high) clears the configuration registers and stage valids.
module texture_lod_request_select
   import lodsel_pkg::*;
#(
   parameter int UV_SETS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lodsel_req_type       req_data,
   output logic                 rsp_strobe,
   output lodsel_rsp_type       rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   // radius lane plus at most three UV lanes
   localparam int NLANES = (UV_SETS - 1 < MAX_LANES - 1) ? UV_SETS : MAX_LANES;

   // ---------------- configuration registers ----------------
   logic        tex_present_ff;
   logic        lod_enable_ff;
   logic [15:0] orig_res_ff;
   logic [31:0] radius_scale_ff;
   logic [31:0] uv_scale_a_ff;
   logic [31:0] uv_scale_b_ff;
   logic [31:0] uv_scale_c_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_present_ff  <= 1'b0;
         lod_enable_ff   <= 1'b0;
         orig_res_ff     <= '0;
         radius_scale_ff <= '0;
         uv_scale_a_ff   <= '0;
         uv_scale_b_ff   <= '0;
         uv_scale_c_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEXTURE_PRESENT: tex_present_ff  <= csr_data[0];
            CSR_LOD_ENABLE:      lod_enable_ff   <= csr_data[0];
            CSR_ORIG_RES:        orig_res_ff     <= csr_data[15:0];
            CSR_RADIUS_SCALE:    radius_scale_ff <= csr_data;
            CSR_UV_SCALE_A:      uv_scale_a_ff   <= csr_data;
            CSR_UV_SCALE_B:      uv_scale_b_ff   <= csr_data;
            CSR_UV_SCALE_C:      uv_scale_c_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------- input transfer and lanes ----------------
   logic accept;
   logic active;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   // LOD math only runs with LOD on and at least one UV density
   assign active = lod_enable_ff && (req_data.uv_count != 2'd0);

   logic [31:0]       lane_den [MAX_LANES];
   logic [31:0]       lane_scl [MAX_LANES];
   logic              lane_en  [MAX_LANES];
   logic [DENS_W-1:0] lane_dens [NLANES];
   logic              lane_use  [NLANES];

   assign lane_den[0] = req_data.world_radius;
   assign lane_den[1] = req_data.uv_density_a;
   assign lane_den[2] = req_data.uv_density_b;
   assign lane_den[3] = req_data.uv_density_c;
   assign lane_scl[0] = radius_scale_ff;
   assign lane_scl[1] = uv_scale_a_ff;
   assign lane_scl[2] = uv_scale_b_ff;
   assign lane_scl[3] = uv_scale_c_ff;

   // UV lane j counts only when active and j <= uv_count; the radius lane whenever active
   assign lane_en[0] = active;
   assign lane_en[1] = active && (req_data.uv_count >= 2'd1);
   assign lane_en[2] = active && (req_data.uv_count >= 2'd2);
   assign lane_en[3] = active && (req_data.uv_count >= 2'd3);

   for (genvar j = 0; j < NLANES; j++) begin : g_lane
      lodsel_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .enable  (lane_en[j]),
         .density (lane_den[j]),
         .scale   (lane_scl[j]),
         .dens_ff (lane_dens[j]),
         .use_ff  (lane_use[j])
      );
   end

   logic        v1_ff;
   logic        s1_active_ff;
   logic        s1_want_ff;
   logic [31:0] s1_screen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_active_ff <= active;
         s1_want_ff   <= req_data.want_bounds;
         s1_screen_ff <= req_data.screen_size;
      end
   end

   // ---------------- merge: smallest positive density ----------------
   // The largest quotient belongs to the smallest density, so one divide
   // of the screen size by the minimum gives the needed resolution.
   logic              merge_any;
   logic [DENS_W-1:0] merge_mind;

   lodsel_merge #(
      .NLANES (NLANES)
   ) u_merge (
      .clock    (clock),
      .dens     (lane_dens),
      .lane_use (lane_use),
      .any_ff   (merge_any),
      .mind_ff  (merge_mind)
   );

   logic        v2_ff;
   logic        s2_active_ff;
   logic        s2_want_ff;
   logic [31:0] s2_screen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_active_ff <= s1_active_ff;
      s2_want_ff   <= s1_want_ff;
      s2_screen_ff <= s1_screen_ff;
   end

   // ---------------- divider ----------------
   lodsel_side_type   div_side_in;
   lodsel_side_type   div_side;
   logic              div_valid;
   logic [DENS_W-1:0] div_quot;

   always_comb begin
      div_side_in.active = s2_active_ff;
      div_side_in.want   = s2_want_ff;
      div_side_in.any    = merge_any;
      div_side_in.screen = s2_screen_ff;
      div_side_in.mind   = merge_mind;
   end

   lodsel_div u_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v2_ff),
      .side_in   (div_side_in),
      .valid_out (div_valid),
      .side_out  (div_side),
      .quot_out  (div_quot)
   );

   // ---------------- LOD stage ----------------
   // lod = floor(log2(orig*2^16 / max(1.0, res))): largest k with rm << k
   // not above orig*2^16, checked for every k at once.
   logic [31:0]        orig_q16;
   logic [DENS_W-1:0]  res_min;
   logic [3:0]         lod_cnt;
   logic               res_pos;
   logic [LOD_W-1:0]   lod_in;
   logic               le1_in;
   logic               above_in;
   logic [31:0]        u_in;
   bound_kind_type     kind_in;

   assign orig_q16 = {orig_res_ff, 16'b0};
   assign res_min  = (div_quot < ONE_Q16) ? ONE_Q16 : div_quot;
   assign res_pos  = div_side.active && div_side.any && (div_side.screen != '0);
   assign le1_in   = (div_quot <= ONE_Q16);
   assign above_in = (div_quot > {32'b0, orig_q16});

   always_comb begin
      lod_cnt = '0;
      for (int k = 1; k < 16; k++) begin
         if (res_min <= ({32'b0, orig_q16} >> k)) begin
            lod_cnt = lod_cnt + 4'd1;
         end
      end
   end

   assign lod_in = res_pos ? {1'b0, lod_cnt} : '0;
   assign u_in   = above_in ? orig_q16 : (orig_q16 >> lod_in);

   always_comb begin
      if (!div_side.want) begin
         kind_in = KIND_NONE;
      end else if (!(div_side.active && div_side.any && (orig_res_ff != '0))) begin
         kind_in = KIND_FREE;
      end else if (!res_pos) begin
         kind_in = KIND_INVALIDATE;
      end else begin
         kind_in = KIND_INTERVAL;
      end
   end

   logic                 vl_ff;
   logic [LOD_W-1:0]     l_lod_ff;
   logic                 l_le1_ff;
   logic                 l_above_ff;
   logic [31:0]          l_u_ff;
   logic [BOUND_W-1:0]   l_m_ff;
   bound_kind_type       l_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= 1'b0;
      end else begin
         vl_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      l_lod_ff   <= lod_in;
      l_le1_ff   <= le1_in;
      l_above_ff <= above_in;
      l_u_ff     <= u_in;
      l_m_ff     <= div_side.mind[DENS_W-1:16];
      l_kind_ff  <= kind_in;
   end

   // ---------------- bound multiply: m * u as two 48x16 halves ----------------
   logic [DENS_W-1:0]  prod_hi;
   logic [DENS_W-1:0]  prod_lo;

   assign prod_hi = {16'b0, l_m_ff} * {48'b0, l_u_ff[31:16]};
   assign prod_lo = {16'b0, l_m_ff} * {48'b0, l_u_ff[15:0]};

   logic                 vp_ff;
   logic [DENS_W-1:0]    p_a_ff;
   logic [BOUND_W-1:0]   p_b_ff;
   logic [LOD_W-1:0]     p_lod_ff;
   logic                 p_le1_ff;
   logic                 p_above_ff;
   logic [BOUND_W-1:0]   p_m_ff;
   bound_kind_type       p_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= vl_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_a_ff     <= prod_hi;
      p_b_ff     <= prod_lo[DENS_W-1:16];
      p_lod_ff   <= l_lod_ff;
      p_le1_ff   <= l_le1_ff;
      p_above_ff <= l_above_ff;
      p_m_ff     <= l_m_ff;
      p_kind_ff  <= l_kind_ff;
   end

   // ---------------- bound finish and result register ----------------
   logic [BOUND_W:0]   psum;
   logic [BOUND_W-1:0] p_sat;
   logic [BOUND_W-1:0] half;
   logic [BOUND_W-1:0] blo;
   logic [BOUND_W-1:0] bhi;
   lodsel_rsp_type     rsp_in;

   assign psum  = {1'b0, p_a_ff[BOUND_W-1:0]} + {1'b0, p_b_ff};
   assign p_sat = (p_a_ff[DENS_W-1:BOUND_W] != '0) ? MAX48 :
                  (psum[BOUND_W] ? MAX48 : psum[BOUND_W-1:0]);
   assign half  = p_sat >> 1;

   always_comb begin
      blo = '0;
      bhi = '0;
      if (p_kind_ff == KIND_INTERVAL) begin
         priority if (p_le1_ff) begin
            // resolution at most one texel: everything below m
            blo = '0;
            bhi = minus_eps(p_m_ff);
         end else if (p_above_ff) begin
            // already past full resolution: unbounded above
            blo = plus_eps(p_sat);
            bhi = MAX48;
         end else begin
            blo = plus_eps((half > p_m_ff) ? half : p_m_ff);
            bhi = minus_eps(p_sat);
         end
      end
      rsp_in.lod_level  = p_lod_ff;
      rsp_in.bound_kind = p_kind_ff;
      rsp_in.bound_low  = blo;
      rsp_in.bound_high = bhi;
   end

   logic           rsp_strobe_ff;
   lodsel_rsp_type rsp_data_ff;

   // no texture bound: the request is dropped here
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vp_ff && tex_present_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* src/lodsel_checker.sv */
// lodsel_checker: port level assertions for texture_lod_request_select,
// bound to the top level. Depends on lodsel_pkg.
module lodsel_checker
   import lodsel_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           busy,
   input logic           rsp_strobe,
   input lodsel_rsp_type rsp_data
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result transfer right after reset");

   a_bounds_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.bound_kind != KIND_INTERVAL)) |->
         ((rsp_data.bound_low == '0) && (rsp_data.bound_high == '0)))
      else $error("bounds set without an interval");

   a_lod_zero_no_interval: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_data.bound_kind == KIND_FREE) ||
                      (rsp_data.bound_kind == KIND_INVALIDATE))) |->
         (rsp_data.lod_level == '0))
      else $error("nonzero LOD with no usable resolution");

   a_lod_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.lod_level <= 5'd15))
      else $error("LOD beyond 16-bit resolution range");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind texture_lod_request_select lodsel_checker u_lodsel_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
